### sv/lfu_pkg.sv
// Shared types and constants for the LFU cache replacement unit.
// Depends on nothing; imported by every module of the block.
package lfu_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_HIT,
        UPD_FILL,
        UPD_REPLACE
    } lfu_upd_op_t;

    // Update command from the decision logic to the slot store.
    typedef struct packed {
        lfu_upd_op_t op;
        logic        write_value;
    } lfu_upd_t;

    // Summary flags of one lookup over all slots.
    typedef struct packed {
        logic hit;
        logic has_free;
        logic any_valid;
    } lfu_look_t;

endpackage

### sv/lfu_lookup.sv
// Parallel lookup over all slots: key match, first free slot, occupancy and
// victim selection (lowest use count, oldest among equals). Uses lfu_pkg.
module lfu_lookup
    import lfu_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic [ENTRIES-1:0]                                slot_valid,
    input  logic [DATA_W-1:0]                                 slot_key   [ENTRIES],
    input  logic [DATA_W-1:0]                                 slot_count [ENTRIES],
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]  slot_rank  [ENTRIES],
    input  logic [DATA_W-1:0]                                 key,
    output lfu_look_t                                         look,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]  found_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]  free_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]  victim_idx,
    output logic [$clog2(ENTRIES+1)-1:0]                      occupancy
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES+1);
    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int KEY_W  = DATA_W + IDX_W;

    logic [ENTRIES-1:0] match;
    logic               has_free;

    // Victim tree: the sort key is the count with the inverted rank below it,
    // so the smallest key is the lowest count and, within it, the oldest.
    logic             node_ok  [NODES];
    logic [KEY_W-1:0] node_key [NODES];
    logic [IDX_W-1:0] node_idx [NODES];

    genvar gi;
    for (gi = 0; gi < ENTRIES; gi++) begin : g_match
        assign match[gi] = slot_valid[gi] & (slot_key[gi] == key);
    end

    for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
        if (gi < ENTRIES) begin : g_used
            assign node_ok[LEAVES-1+gi]  = slot_valid[gi];
            assign node_key[LEAVES-1+gi] = {slot_count[gi], ~slot_rank[gi]};
            assign node_idx[LEAVES-1+gi] = IDX_W'(gi);
        end
        else begin : g_pad
            assign node_ok[LEAVES-1+gi]  = 1'b0;
            assign node_key[LEAVES-1+gi] = '0;
            assign node_idx[LEAVES-1+gi] = '0;
        end
    end

    for (gi = 0; gi < LEAVES-1; gi++) begin : g_node
        logic pick_left;
        assign pick_left = node_ok[2*gi+1]
                         & (!node_ok[2*gi+2] | (node_key[2*gi+1] <= node_key[2*gi+2]));
        assign node_ok[gi]  = node_ok[2*gi+1] | node_ok[2*gi+2];
        assign node_key[gi] = pick_left ? node_key[2*gi+1] : node_key[2*gi+2];
        assign node_idx[gi] = pick_left ? node_idx[2*gi+1] : node_idx[2*gi+2];
    end

    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                found_idx = found_idx | IDX_W'(i);
            end
        end
    end

    // Scanning downward leaves the lowest-numbered free slot selected.
    always_comb
    begin
        free_idx = '0;
        has_free = 1'b0;
        for (int i = ENTRIES-1; i >= 0; i--)
        begin
            if (!slot_valid[i])
            begin
                free_idx = IDX_W'(i);
                has_free = 1'b1;
            end
        end
    end

    assign occupancy      = OCC_W'($countones(slot_valid));
    assign victim_idx     = node_idx[0];
    assign look.hit       = |match;
    assign look.has_free  = has_free;
    assign look.any_valid = node_ok[0];

endmodule

### sv/lfu_slot_array.sv
// Slot store of the LFU cache: valid bits, keys, values, use counts and
// recency ranks, updated by one command per cycle. Uses lfu_pkg.
module lfu_slot_array
    import lfu_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  lfu_upd_t                                          upd,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]  upd_idx,
    input  logic [DATA_W-1:0]                                 upd_key,
    input  logic [DATA_W-1:0]                                 upd_value,
    output logic [ENTRIES-1:0]                                slot_valid,
    output logic [DATA_W-1:0]                                 slot_key   [ENTRIES],
    output logic [DATA_W-1:0]                                 slot_value [ENTRIES],
    output logic [DATA_W-1:0]                                 slot_count [ENTRIES],
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]  slot_rank  [ENTRIES]
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] valid_reg;
    logic [DATA_W-1:0]  key_reg    [ENTRIES];
    logic [DATA_W-1:0]  value_reg  [ENTRIES];
    logic [DATA_W-1:0]  count_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_reg   [ENTRIES];
    logic [DATA_W-1:0]  key_next   [ENTRIES];
    logic [DATA_W-1:0]  value_next [ENTRIES];
    logic [DATA_W-1:0]  count_next [ENTRIES];
    logic [IDX_W-1:0]   rank_next  [ENTRIES];
    logic [IDX_W-1:0]   sel_rank;

    assign sel_rank = rank_reg[upd_idx];

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];
            unique case (upd.op)
                UPD_HIT:
                begin
                    if (upd_idx == IDX_W'(i))
                    begin
                        rank_next[i] = '0;
                        if (count_reg[i] != COUNT_MAX)
                        begin
                            count_next[i] = count_reg[i] + 1'b1;
                        end
                        if (upd.write_value)
                        begin
                            value_next[i] = upd_value;
                        end
                    end
                    else if (valid_reg[i] && (rank_reg[i] < sel_rank))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                UPD_REPLACE:
                begin
                    if (upd_idx == IDX_W'(i))
                    begin
                        rank_next[i]  = '0;
                        count_next[i] = DATA_W'(1);
                        key_next[i]   = upd_key;
                        value_next[i] = upd_value;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < sel_rank))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                UPD_FILL:
                begin
                    // A new entry with room ages every entry already held.
                    if (upd_idx == IDX_W'(i))
                    begin
                        rank_next[i]  = '0;
                        count_next[i] = DATA_W'(1);
                        key_next[i]   = upd_key;
                        value_next[i] = upd_value;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if ((upd.op == UPD_FILL) || (upd.op == UPD_REPLACE))
        begin
            valid_reg[upd_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
            count_reg[i] <= count_next[i];
            rank_reg[i]  <= rank_next[i];
        end
    end

    assign slot_valid = valid_reg;
    assign slot_key   = key_reg;
    assign slot_value = value_reg;
    assign slot_count = count_reg;
    assign slot_rank  = rank_reg;

endmodule

### sv/lfu_cache_replacement_unit.sv
// Top level of the LFU cache replacement unit: APB register, input register,
// decision logic and result register. Uses lfu_pkg, lfu_lookup, lfu_slot_array.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  request  | start & !busy          | action, key, value
//  result   | done (one cycle)       | hit, read_value, evicted, evicted_key
//  config   | psel & penable & pwrite| paddr, pwdata (capacity_in_use), prdata
//
// A request beat is taken in any cycle; busy stays low. The lookup and slot
// update run combinationally between the input register and the result
// register, so the result is on the ports once the result register has taken
// it. Each beat sees the slot updates of the beat before it. Reset clears all
// slot valid bits and sets the capacity to 16.
// The receiver cannot stall; done marks a result for exactly one cycle.
module lfu_cache_replacement_unit
    import lfu_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic                     action,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     evicted,
    output logic signed [DATA_W-1:0] evicted_key
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES+1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    logic              req_valid_reg;
    logic              act_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;
    logic              done_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              evicted_reg;
    logic [DATA_W-1:0] evicted_key_reg;

    logic [ENTRIES-1:0] slot_valid;
    logic [DATA_W-1:0]  slot_key   [ENTRIES];
    logic [DATA_W-1:0]  slot_value [ENTRIES];
    logic [DATA_W-1:0]  slot_count [ENTRIES];
    logic [IDX_W-1:0]   slot_rank  [ENTRIES];

    lfu_look_t          look;
    logic [IDX_W-1:0]   found_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic [OCC_W-1:0]   occupancy;

    lfu_upd_t           upd;
    logic [IDX_W-1:0]   upd_idx;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   occ_ext;
    logic               is_put;
    logic               evict_now;
    logic [DATA_W-1:0]  read_value_next;
    logic [DATA_W-1:0]  evicted_key_next;
    logic               accept;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start & ~busy;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = 32'(cap_reg);

    lfu_slot_array #(
        .ENTRIES    (ENTRIES)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .upd_idx    (upd_idx),
        .upd_key    (key_reg),
        .upd_value  (val_reg),
        .slot_valid (slot_valid),
        .slot_key   (slot_key),
        .slot_value (slot_value),
        .slot_count (slot_count),
        .slot_rank  (slot_rank)
    );

    lfu_lookup #(
        .ENTRIES    (ENTRIES)
    ) u_lookup (
        .slot_valid (slot_valid),
        .slot_key   (slot_key),
        .slot_count (slot_count),
        .slot_rank  (slot_rank),
        .key        (key_reg),
        .look       (look),
        .found_idx  (found_idx),
        .free_idx   (free_idx),
        .victim_idx (victim_idx),
        .occupancy  (occupancy)
    );

    // Capacities above the slot count behave as the slot count.
    assign cap_ext = CMP_W'(cap_reg);
    assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign occ_ext = CMP_W'(occupancy);
    assign is_put  = (act_reg == ACT_PUT);

    always_comb
    begin
        upd.op          = UPD_NONE;
        upd.write_value = 1'b0;
        upd_idx         = found_idx;
        evict_now       = 1'b0;
        if (req_valid_reg)
        begin
            if (!is_put)
            begin
                if (look.hit)
                begin
                    upd.op = UPD_HIT;
                end
            end
            else if (cap_eff != '0)
            begin
                if (look.hit)
                begin
                    upd.op          = UPD_HIT;
                    upd.write_value = 1'b1;
                end
                else if ((occ_ext >= cap_eff) && look.any_valid)
                begin
                    upd.op    = UPD_REPLACE;
                    upd_idx   = victim_idx;
                    evict_now = 1'b1;
                end
                else
                begin
                    upd.op  = UPD_FILL;
                    upd_idx = free_idx;
                end
            end
        end
    end

    assign read_value_next  = (!is_put && look.hit) ? slot_value[found_idx] : '1;
    assign evicted_key_next = evict_now ? slot_key[victim_idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            req_valid_reg <= accept;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
        end
        if (req_valid_reg)
        begin
            hit_reg         <= look.hit;
            read_value_reg  <= read_value_next;
            evicted_reg     <= evict_now;
            evicted_key_reg <= evicted_key_next;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

`ifndef SYNTHESIS
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted beat did not produce a result two cycles later");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> !hit)
        else $error("eviction reported on a key that was present");

    a_miss_reads_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (read_value == '1))
        else $error("miss returned a value other than minus one");
`endif

endmodule
